// ===== design/mdet_pkg.sv =====
// shared types and constants for the matrix determinant block
package mdet_pkg;

  // width of the determinant result and of every stored minor
  localparam int unsigned DET_W = 52;
  // width of the size register
  localparam int unsigned SIZE_W = 3;
  // reset value of the size register
  localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd2;
  // register index of the size register
  localparam logic REG_SIZE = 1'b0;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

endpackage

// ===== design/matrix_determinant_top.sv =====
// Sequencing: after the last entry, each column subset (n = matrix size) is scanned over all n
//   columns, drained from the multiply pipeline and written to the minor ram, in that order.
// Throughput: entries load one per cycle, only in the load state; the minor pass runs once per matrix,
//   one column per cycle through a shared multiply-accumulate fed from the entry and minor rams.
// The minor ram holds the determinant of every column subset of the lower rows.
// Reset: synchronous, active high; size returns to 2, load count and sequencer clear.
// Ram contents are not cleared; entries are always written before they are read.
module matrix_determinant_top #(
  parameter int unsigned MAX_SIZE   = 6,
  parameter int unsigned ENTRY_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // apb configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] entry_value
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [55:0]                m_tdata    // [51:0] determinant, [55:52] zero
);
  import mdet_pkg::*;

  localparam int unsigned DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned COL_W  = $clog2(MAX_SIZE);
  localparam int unsigned N_W    = $clog2(MAX_SIZE + 1);
  localparam int unsigned MASK_W = MAX_SIZE;

  state_t state;
  logic [SIZE_W-1:0] matrix_size;
  logic [CNT_W-1:0]  load_count;
  logic [N_W-1:0]    n;
  logic [CNT_W-1:0]  total;
  logic [MASK_W-1:0] mask;
  logic [MASK_W-1:0] full_mask;
  logic [COL_W-1:0]  col;
  logic              neg;
  logic              v1, v2, sign1, sign2;
  logic signed [DET_W-1:0] prod;
  logic signed [DET_W-1:0] acc;
  logic [N_W-1:0]    pop;
  logic [N_W-1:0]    row;
  logic [IDX_W-1:0]  ent_raddr;
  logic [MASK_W-1:0] det_raddr;
  logic [ENTRY_BITS-1:0] ent_rdata;
  logic [DET_W-1:0]  det_rdata;
  logic              cfg_wr, in_acc, out_acc, issue, last_col;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_SIZE) ? 32'(matrix_size) : 32'd0;
  assign s_tready = (state == ST_LOAD);

  // effective size, saturated into 1..MAX_SIZE
  always_comb begin
    if (matrix_size == '0) begin
      n = N_W'(1);
    end else if (int'(matrix_size) > int'(MAX_SIZE)) begin
      n = N_W'(MAX_SIZE);
    end else begin
      n = N_W'(matrix_size);
    end
    total     = CNT_W'(n) * CNT_W'(n);
    full_mask = MASK_W'((MASK_W+1)'(1) << n) - MASK_W'(1);
  end

  // row of the current subset and read addresses of the next term
  always_comb begin
    pop = '0;
    for (int i = 0; i < int'(MASK_W); i++) begin
      pop = pop + N_W'(mask[i]);
    end
    row       = n - pop;
    ent_raddr = IDX_W'(IDX_W'(row) * IDX_W'(n) + IDX_W'(col));
    det_raddr = mask & ~(MASK_W'(1) << col);
    issue     = (state == ST_SCAN) && mask[col];
    last_col  = (N_W'(col) == n - N_W'(1));
  end

  // matrix entries, row-major
  mdet_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (IDX_W'(load_count)),
    .wdata (s_tdata[ENTRY_BITS-1:0]),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // minor determinants indexed by column subset
  mdet_ram #(.WIDTH(DET_W), .DEPTH(2 ** MASK_W)) u_det_ram (
    .clk   (clk),
    .we    (state == ST_WRITE),
    .waddr (mask),
    .wdata (acc),
    .raddr (det_raddr),
    .rdata (det_rdata)
  );

  // multiply and accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
    sign1 <= neg;
    sign2 <= sign1;
    prod  <= DET_W'($signed(ent_rdata)) * $signed(det_rdata);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      matrix_size <= SIZE_RESET;
      load_count  <= '0;
      m_tvalid    <= 1'b0;
      mask        <= '0;
      col         <= '0;
      neg         <= 1'b0;
    end else begin
      if (out_acc) begin
        m_tvalid <= 1'b0;
      end
      if (v2) begin
        acc <= sign2 ? acc - prod : acc + prod;
      end
      if (cfg_wr && paddr[2] == REG_SIZE && paddr[1:0] == 2'b00) begin
        matrix_size <= pwdata[SIZE_W-1:0];
        load_count  <= '0;
      end
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (load_count + CNT_W'(1) == total) begin
              load_count <= '0;
              mask       <= '0;
              acc        <= DET_W'(1);
              state      <= ST_WRITE;
            end else begin
              load_count <= load_count + CNT_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            neg <= ~neg;
          end
          if (last_col) begin
            state <= ST_DRAIN;
          end else begin
            col <= col + COL_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (mask == full_mask) begin
            if (!m_tvalid || out_acc) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {4'd0, acc};
              state    <= ST_LOAD;
            end else begin
              state <= ST_HOLD;
            end
          end else begin
            mask  <= mask + MASK_W'(1);
            acc   <= '0;
            col   <= '0;
            neg   <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_HOLD: begin
          if (!m_tvalid || out_acc) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, acc};
            state    <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a minor is stored only once all its terms have been summed
  a_write_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |-> !v1 && !v2)
    else $error("minor written with terms in flight");

  // terms are issued only while scanning columns
  a_issue_scan: assert property (@(posedge clk) disable iff (rst)
    v1 |-> $past(state) == ST_SCAN)
    else $error("term issued outside scan");

  // loading never runs past the matrix
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> load_count < total)
    else $error("load count beyond matrix");

  // a result comes only from the full column subset
  a_result_full: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(mask) == $past(full_mask))
    else $error("result from partial subset");
`endif

endmodule

// ===== design/mdet_ram.sv =====
// generic single write port, single read port ram with registered read
module mdet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/mdet_checker.sv =====
// determinant checker: watches both streams and the size register, predicts and compares
module mdet_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  output int          fail_count,
  output int          pending,
  output int          det_seen
);
  import mdet_pkg::*;

  logic signed [7:0]  entries [36];
  logic [2:0]         size_reg;
  int                 loaded;
  logic [51:0]        det_queue [$];

  // effective size, zero taken as one, above six saturated
  function automatic int unsigned eff_size(input logic [2:0] s);
    if (s == 0) return 1;
    if (s > 6) return 6;
    return s;
  endfunction

  // cofactor expansion over rows row..n-1 and the column subset in cols
  function automatic longint minor_det(input int unsigned row, input int unsigned cols,
                                       input int unsigned n);
    longint sum;
    int     pos;
    sum = 0;
    pos = 0;
    for (int c = 0; c < n; c++) begin
      if (cols[c]) begin
        if (row + 1 >= n) return longint'(entries[row*n + c]);
        if (pos % 2 == 1)
          sum -= longint'(entries[row*n + c]) * minor_det(row + 1, cols & ~(1 << c), n);
        else
          sum += longint'(entries[row*n + c]) * minor_det(row + 1, cols & ~(1 << c), n);
        pos++;
      end
    end
    return sum;
  endfunction

  assign pending = det_queue.size();

  always @(posedge clk) begin
    int unsigned n;
    longint      d;
    if (rst) begin
      size_reg   <= SIZE_RESET;
      loaded     = 0;
      fail_count <= 0;
      det_seen   <= 0;
      det_queue.delete();
    end else begin
      // size write restarts the load
      if (psel && penable && pwrite && pready && paddr[2] == REG_SIZE) begin
        size_reg <= pwdata[2:0];
        loaded   = 0;
      end
      // input transaction
      if (s_tvalid && s_tready) begin
        n = eff_size(size_reg);
        entries[loaded] = s_tdata;
        loaded++;
        if (loaded >= n*n) begin
          loaded = 0;
          d = minor_det(0, (1 << n) - 1, n);
          det_queue.push_back(d[51:0]);
        end
      end
      // output transaction
      if (m_tvalid && m_tready) begin
        det_seen <= det_seen + 1;
        if (det_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected determinant %h", m_tdata);
        end else begin
          if (m_tdata !== {4'h0, det_queue[0]}) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("determinant mismatch: expected %h actual %h", det_queue[0], m_tdata);
          end
          void'(det_queue.pop_front());
        end
      end
    end
  end
endmodule

// ===== verif/tb_matrix_determinant_top.sv =====
// testbench top: drives matrices and size writes, gives the verdict
module tb_matrix_determinant_top;
  import mdet_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;    // [7:0] entry_value
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;        // [51:0] determinant, [55:52] zero
  int          fail_count, pending, det_seen;
  int          cycles = 0;
  int          sent = 0;
  int          sink_wait = 0;
  bit          hold_off = 0;
  bit          sink_on = 0;
  int unsigned cur_size = 2;

  always #5 clk = ~clk;

  matrix_determinant_top DUT (.*);

  mdet_checker chk (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // new wait drawn after every output transaction
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sink_wait = $urandom_range(0, 6);
  end

  // receiver with random waits and one long hold-off
  always @(negedge clk) begin
    if (sink_on) begin
      if (hold_off) m_tready <= 0;
      else if (sink_wait > 0) begin
        m_tready <= 0;
        sink_wait--;
      end else m_tready <= 1;
    end
  end

  // one size register write, block idle
  task automatic write_size(input logic [2:0] s);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= {REG_SIZE, 2'b00}; pwdata <= {29'd0, s};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    cur_size = (s == 0) ? 1 : (s > 6) ? 6 : s;
  endtask

  // wait until every determinant has come, then let the pass settle
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  // one entry transaction, random gap before it unless gapless
  task automatic send_entry(input logic [7:0] v, input bit gapless);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_matrix(input int kind, input bit gapless);
    logic [7:0] v;
    for (int i = 0; i < cur_size*cur_size; i++) begin
      case (kind)
        0: v = 8'h80;
        1: v = 8'h7f;
        2: v = (i % (cur_size + 1) == 0) ? 8'h80 : 8'h00;
        3: v = ((i / cur_size + i % cur_size) % 2) ? 8'h80 : 8'h7f;
        default: v = 8'($urandom_range(0, 255));
      endcase
      send_entry(v, gapless);
    end
    s_tvalid <= 0;
  endtask

  initial begin
    logic [2:0] sz;
    repeat (2) @(negedge clk);
    rst <= 0;
    sink_on = 1;
    // directed: reset size, then every size including zero and saturation
    for (int k = 0; k < 4; k++) send_matrix(k, 0);
    drain();
    for (int s = 0; s < 8; s++) begin
      write_size(s[2:0]);
      send_matrix(s % 4, 0);
      drain();
    end
    // abandoned partial load followed by a size write
    write_size(3'd3);
    send_entry(8'h55, 0);
    send_entry(8'haa, 0);
    s_tvalid <= 0;
    repeat (50) @(negedge clk);
    write_size(3'd2);
    send_matrix(4, 0);
    drain();
    // long receiver hold-off while small matrices keep coming
    write_size(3'd1);
    hold_off = 1;
    fork
      begin repeat (300) @(negedge clk); hold_off = 0; end
      for (int m = 0; m < 40; m++) send_matrix(4, 1);
    join
    drain();
    // random phases, mostly small sizes
    while (sent < 1250) begin
      sz = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      write_size(sz);
      repeat ($urandom_range(2, 12)) send_matrix(($urandom_range(0, 7) == 0) ?
                                                 $urandom_range(0, 3) : 4, 0);
      drain();
    end
    $display("sent %0d entries over sizes 0..7, %0d determinants checked", sent, det_seen);
    $display("covered extreme entries, size saturation, aborted load and output back-pressure");
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
